/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/modexp_pkg.sv */
// Package for the modular exponentiation block: widths, register indexes, reset values.
// No dependencies.
package modexp_pkg;

    localparam int WORD_WIDTH_DEFAULT = 32;
    localparam int FIELD_WIDTH        = 32;
    localparam int CFG_INDEX_WIDTH    = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 2'd1;

    localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd1;
    localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'd1;

endpackage

/* rtl/modular_exponentiation_top.sv */
// Modular exponentiation, right-to-left binary square-and-multiply, bit-serial datapath.
// Depends on modexp_pkg and assert_macros.svh.
//
// An item is taken when start is high and busy is low; base is raised to the exponent
// register modulo the modulus register. One shared bit-serial modular multiplier does all
// the work, one multiplier bit per cycle, and each reduction or product is one pass over
// the word: one pass reduces the base, one multiply pass follows per set exponent bit and
// one square pass per exponent bit below the top set bit, so 1 + popcount(e) + index of
// the top set bit of e passes in all; a zero exponent answers 1 after the reduction. The
// result appears on power_mod with done high for exactly one cycle and must be taken
// then: there is no way to hold it off. busy drops in the same cycle, so the next item
// may start at once. A modulus whose low WORD_WIDTH bits are zero behaves as
// 2^WORD_WIDTH. Register writes are always taken (cfg_ready is tied high); write them
// only while the block is idle.

`include "assert_macros.svh"

module modular_exponentiation_top #(
    parameter int WORD_WIDTH = modexp_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0]     base,
    output logic                                   busy,
    output logic                                   done,
    output logic [modexp_pkg::FIELD_WIDTH-1:0]     power_mod,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0]     cfg_data
);

    localparam int CW = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
    localparam int FW = modexp_pkg::FIELD_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] scan_reg, scan_next;
    logic [WORD_WIDTH-1:0] add_reg, add_next;
    logic [WORD_WIDTH-1:0] r_reg, r_next;
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] bmod_reg, bmod_next;
    logic [WORD_WIDTH-1:0] exp_reg, exp_next;
    logic                  done_reg, done_next;
    logic [FW-1:0]         power_mod_reg, power_mod_next;
    logic [FW-1:0]         exponent_reg;
    logic [FW-1:0]         modulus_reg;

    logic [WORD_WIDTH-1:0] mod_w;
    logic [WORD_WIDTH-1:0] one_w;
    logic [WORD_WIDTH-1:0] add_sel;
    logic [WORD_WIDTH+1:0] t_sum;
    logic [WORD_WIDTH+2:0] d1;
    logic [WORD_WIDTH+2:0] d2;
    logic [WORD_WIDTH-1:0] r_step;
    logic                  last;
    logic                  accept;

    assign mod_w     = modulus_reg[WORD_WIDTH-1:0];
    assign one_w     = WORD_WIDTH'(1);
    assign last      = (cnt_reg == CW'(WORD_WIDTH - 1));
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign power_mod = power_mod_reg;
    assign cfg_ready = 1'b1;

    // r' = 2r + bit*a, reduced by up to two subtractions of the modulus
    always_comb
    begin
        add_sel = scan_reg[WORD_WIDTH-1] ? add_reg : '0;
        t_sum   = {1'b0, r_reg, 1'b0} + {2'b00, add_sel};
        d1      = {1'b0, t_sum} - {3'b000, mod_w};
        d2      = {1'b0, t_sum} - {2'b00, mod_w, 1'b0};
        if (!d2[WORD_WIDTH+2])
        begin
            r_step = d2[WORD_WIDTH-1:0];
        end
        else if (!d1[WORD_WIDTH+2])
        begin
            r_step = d1[WORD_WIDTH-1:0];
        end
        else
        begin
            r_step = t_sum[WORD_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        add_next       = add_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        bmod_next      = bmod_reg;
        exp_next       = exp_reg;
        done_next      = 1'b0;
        power_mod_next = power_mod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_REDUCE;
                    cnt_next   = '0;
                    scan_next  = base[WORD_WIDTH-1:0];
                    add_next   = (mod_w == one_w) ? '0 : one_w;
                    r_next     = '0;
                    acc_next   = one_w;
                    exp_next   = exponent_reg[WORD_WIDTH-1:0];
                end
            end
            default:
            begin
                r_next    = r_step;
                scan_next = scan_reg << 1;
                cnt_next  = cnt_reg + CW'(1);
                if (last)
                begin
                    cnt_next = '0;
                    r_next   = '0;
                    unique case (state_reg)
                        ST_REDUCE:
                        begin
                            bmod_next = r_step;
                            if (exp_reg == '0)
                            begin
                                state_next     = ST_IDLE;
                                done_next      = 1'b1;
                                power_mod_next = FW'(one_w);
                            end
                            else if (exp_reg[0])
                            begin
                                state_next = ST_MUL;
                                scan_next  = acc_reg;
                                add_next   = r_step;
                            end
                            else
                            begin
                                state_next = ST_SQR;
                                scan_next  = r_step;
                                add_next   = r_step;
                            end
                        end
                        ST_MUL:
                        begin
                            acc_next = r_step;
                            if ((exp_reg >> 1) == '0)
                            begin
                                state_next     = ST_IDLE;
                                done_next      = 1'b1;
                                power_mod_next = FW'(r_step);
                            end
                            else
                            begin
                                state_next = ST_SQR;
                                scan_next  = bmod_reg;
                                add_next   = bmod_reg;
                            end
                        end
                        default:
                        begin
                            bmod_next = r_step;
                            exp_next  = exp_reg >> 1;
                            if (exp_reg[1])
                            begin
                                state_next = ST_MUL;
                                scan_next  = acc_reg;
                                add_next   = r_step;
                            end
                            else
                            begin
                                state_next = ST_SQR;
                                scan_next  = r_step;
                                add_next   = r_step;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            power_mod_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            power_mod_reg <= power_mod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        add_reg  <= add_next;
        r_reg    <= r_next;
        acc_reg  <= acc_next;
        bmod_reg <= bmod_next;
        exp_reg  <= exp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= modexp_pkg::EXPONENT_RESET;
            modulus_reg  <= modexp_pkg::MODULUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                modexp_pkg::REG_EXPONENT: exponent_reg <= cfg_data;
                modexp_pkg::REG_MODULUS:  modulus_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `ASSERT_IMPLIES(a_busy_from_start, clk, rst_n, $rose(busy), $past(start))

endmodule

/* test/modular_exponentiation_top_tb.sv */
// Testbench for modular_exponentiation_top: a table of directed items, then random phases,
// each item checked against its typed-in answer or a bit-accurate square-and-multiply predictor.
// Depends on modexp_pkg and the RTL of modular_exponentiation_top.
module modular_exponentiation_top_tb;

    localparam int W              = modexp_pkg::FIELD_WIDTH;
    localparam int IW             = modexp_pkg::CFG_INDEX_WIDTH;
    localparam int DIRECTED_COUNT = 22;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 28;
    localparam int ITEM_CYCLES    = 2100;
    localparam int LONG_GAP       = 2200;
    localparam int CYCLE_LIMIT    =
        (DIRECTED_COUNT + PHASES * PHASE_ITEMS) * (ITEM_CYCLES + LONG_GAP) * 2;

    // indexes that decode to no register
    localparam logic [IW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IW-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [W-1:0] exponent;
        logic [W-1:0] modulus;
        logic [W-1:0] operand;
        logic         known;
        logic [W-1:0] answer;
    } vector_t;

    // exponent, modulus, base, answer typed in?, answer
    vector_t directed_vectors [DIRECTED_COUNT] = '{
        '{32'd1,          32'd1,          32'h0000_0000, 1'b1, 32'd0},
        '{32'd1,          32'd1,          32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'd0,          32'd1,          32'h1234_5678, 1'b1, 32'd1},
        '{32'd0,          32'hFFFF_FFFF,  32'h0000_0000, 1'b1, 32'd1},
        '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
        '{32'd2,          32'hFFFF_FFFF,  32'h0001_0000, 1'b1, 32'd1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'h0000_0001, 1'b1, 32'd1},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'h0000_0000, 1'b1, 32'd0},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFB,  32'hDEAD_BEEF, 1'b0, 32'd0},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFB,  32'hFFFF_FFFF, 1'b0, 32'd0},
        '{32'd17,         32'd3233,       32'd65,        1'b1, 32'd2790},
        '{32'd2753,       32'd3233,       32'd2790,      1'b1, 32'd65},
        '{32'd65537,      32'h8000_0000,  32'd3,         1'b0, 32'd0},
        '{32'h8000_0000,  32'd1000000007, 32'd2,         1'b0, 32'd0},
        '{32'd5,          32'd2,          32'd7,         1'b1, 32'd1},
        '{32'd4,          32'd2,          32'd6,         1'b1, 32'd0},
        '{32'h8000_0000,  32'hFFFF_FFFB,  32'h8000_0000, 1'b0, 32'd0},
        '{32'hAAAA_AAAA,  32'h5555_5555,  32'h1234_5678, 1'b0, 32'd0},
        '{32'h5555_5555,  32'hAAAA_AAAB,  32'hCAFE_F00D, 1'b0, 32'd0},
        '{32'd3,          32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'd0},
        '{32'd1,          32'h8000_0000,  32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF}
    };

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          start     = 1'b0;
    logic [W-1:0]  base      = '0;
    logic          cfg_valid = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [W-1:0]  cfg_data  = '0;
    logic          busy;
    logic          done;
    logic          cfg_ready;
    logic [W-1:0]  power_mod;

    logic [W-1:0] exponent_reg = modexp_pkg::EXPONENT_RESET;
    logic [W-1:0] modulus_reg  = modexp_pkg::MODULUS_RESET;
    logic [W-1:0] pending_powers [$];
    int           failures    = 0;
    int           cycle_count = 0;
    bit           calm        = 1'b0;

    modular_exponentiation_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .base      (base),
        .busy      (busy),
        .done      (done),
        .power_mod (power_mod),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] reduce_word(input logic [63:0] x, input logic [63:0] m);
        if (m == 64'd0)
            return {32'd0, x[31:0]};
        return x % m;
    endfunction

    // right-to-left square and multiply, result left unreduced while never multiplied
    function automatic logic [W-1:0] predict_power_mod(input logic [W-1:0] b,
                                                       input logic [W-1:0] e_in,
                                                       input logic [W-1:0] m_in);
        logic [63:0]  acc;
        logic [63:0]  sq;
        logic [63:0]  m;
        logic [W-1:0] e;
        acc = 64'd1;
        sq  = {32'd0, b};
        m   = {32'd0, m_in};
        e   = e_in;
        for (int i = 0; i < modexp_pkg::WORD_WIDTH_DEFAULT; i++)
        begin
            if (e == '0)
                break;
            if (e[0])
                acc = reduce_word(acc * sq, m);
            sq = reduce_word(sq * sq, m);
            e  = e >> 1;
        end
        return acc[W-1:0];
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(17, LONG_GAP);
        return $urandom_range(1, 16);
    endfunction

    task automatic send_base(input logic [W-1:0] value, input logic known,
                             input logic [W-1:0] answer);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
        start <= 1'b1;
        base  <= value;
        do @(posedge clk); while (busy);
        pending_powers.push_back(known ? answer
                                       : predict_power_mod(value, exponent_reg, modulus_reg));
    endtask

    task automatic set_register(input logic [IW-1:0] index,
                                input logic [W-1:0] value);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            cfg_valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            modexp_pkg::REG_EXPONENT: exponent_reg = value;
            modexp_pkg::REG_MODULUS:  modulus_reg  = value;
            default: ;
        endcase
    endtask

    // every item gives a result, so an empty queue means the block is idle
    task automatic settle();
        start <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [W-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2, 3, 4: return $urandom_range(2, 255);
            5, 6:    return $urandom_range(256, 65535);
            7:       return 32'd65537;
            8:       return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [W-1:0] pick_modulus();
        logic [W-1:0] m;
        case ($urandom_range(0, 9))
            0:          m = 32'd1;
            1:          m = 32'd2;
            2, 3:       m = $urandom_range(3, 65535);
            4, 5, 6:    m = $urandom;
            7:          m = 32'hFFFF_FFFF;
            8:          m = 32'h8000_0000;
            default:    m = 32'hFFFF_FFFB;
        endcase
        return (m == '0) ? 32'd1 : m;
    endfunction

    function automatic logic [W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return modulus_reg - 32'd1;
            3:       return modulus_reg;
            4:       return $urandom % modulus_reg;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        logic [W-1:0] want;
        if (rst_n && done)
        begin
            if (pending_powers.size() == 0)
            begin
                $error("power_mod: expected none, actual %h", power_mod);
                failures++;
            end
            else
            begin
                want = pending_powers.pop_front();
                if (power_mod !== want)
                begin
                    $error("power_mod: expected %h, actual %h", want, power_mod);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("modular_exponentiation_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        vector_t row;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table rows; the first two run on the reset values
        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            row = directed_vectors[r];
            if (row.exponent != exponent_reg || row.modulus != modulus_reg)
            begin
                settle();
                set_register(modexp_pkg::REG_EXPONENT, row.exponent);
                set_register(modexp_pkg::REG_MODULUS, row.modulus);
                cfg_valid <= 1'b0;
            end
            send_base(row.operand, row.known, row.answer);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == 4 || p == 5);
            settle();
            if (p == 1)
            begin
                set_register(modexp_pkg::REG_EXPONENT, $urandom);
                set_register(modexp_pkg::REG_MODULUS, $urandom | 32'd1);
            end
            else
            begin
                set_register(modexp_pkg::REG_EXPONENT, pick_exponent());
                set_register(modexp_pkg::REG_MODULUS, pick_modulus());
            end
            if ($urandom_range(0, 1))
                set_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            cfg_valid <= 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_base(pick_base(), 1'b0, '0);
        end

        settle();
        repeat (ITEM_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("modular_exponentiation_top_tb: PASS");
        else
            $display("modular_exponentiation_top_tb: FAIL");
        $finish;
    end

endmodule
